[src/ieb_pkg.sv]
`timescale 1ns / 1ps

package ieb_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam logic [6:0] RESET_ADDRESS = 7'd42;
  localparam logic [7:0] EMPTY_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    ACT_ADDRESSED = 3'd0,
    ACT_READ      = 3'd1,
    ACT_WRITE     = 3'd2,
    ACT_STOP      = 3'd3,
    ACT_ERROR     = 3'd4
  } action_t;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] bus_address;
    logic [7:0] write_data;
  } event_t;

  typedef struct packed {
    logic       ack;
    logic [7:0] read_data;
    logic       read_valid;
  } result_t;

endpackage

[src/ieb_event_if.sv]
`timescale 1ns / 1ps

interface ieb_event_if;
  logic            valid;
  logic            ready;
  ieb_pkg::event_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/ieb_result_if.sv]
`timescale 1ns / 1ps

interface ieb_result_if;
  logic             valid;
  logic             ready;
  ieb_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/i2c_target_echo_buffer.sv]
`timescale 1ns / 1ps

// I2C target echo buffer: takes one bus event per beat on req (address phase, master read,
// master write, stop, error) and returns one result beat on rsp. Received and transmit
// bytes live in two banks of one synchronous RAM; an address phase after received bytes
// swaps the banks instead of copying. The RAM read and the decoded event are registered when
// the event is accepted, and the result register loads from them once the result side has
// room. A new event is accepted every cycle while the result side keeps taking beats; with
// rsp stalled the block holds two events and then drops req.ready. own_address is written
// through cfg_we/cfg_wdata; the user must do so only while the block is idle, which the
// block itself does not enforce. own_address resets to 42.
module i2c_target_echo_buffer #(
  parameter int BUFFER_DEPTH = ieb_pkg::BUFFER_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,
  ieb_event_if.sink    req,
  ieb_result_if.source rsp
);

  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam logic [CW-1:0] FULL = CW'(BUFFER_DEPTH);
  localparam logic [CW-1:0] LAST = CW'(BUFFER_DEPTH - 1);

  logic [7:0] mem [2][BUFFER_DEPTH];

  logic [6:0]    own_address;
  logic [CW-1:0] rx_count, rx_count_next;
  logic [CW-1:0] tx_count, tx_count_next;
  logic [CW-1:0] tx_pos, tx_pos_next;
  logic          rx_bank, rx_bank_next;

  logic          pend;
  logic          pend_ack, pend_ack_next;
  logic          pend_hit, pend_hit_next;
  logic [7:0]    pend_byte, pend_byte_next;
  logic [7:0]    rd_data;

  logic          out_valid;
  ieb_pkg::result_t out_data;

  logic          accept, move, wr_en;

  assign move      = pend && (!out_valid || rsp.ready);
  assign req.ready = !pend || move;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_comb begin
    rx_count_next  = rx_count;
    tx_count_next  = tx_count;
    tx_pos_next    = tx_pos;
    rx_bank_next   = rx_bank;
    pend_ack_next  = 1'b1;
    pend_hit_next  = 1'b0;
    pend_byte_next = 8'd0;
    wr_en          = 1'b0;
    case (req.data.action)
      ieb_pkg::ACT_ADDRESSED: begin
        pend_ack_next = (req.data.bus_address == own_address);
        if (rx_count != '0) begin
          tx_count_next = rx_count;
          rx_count_next = '0;
          tx_pos_next   = '0;
          rx_bank_next  = !rx_bank;
        end
      end
      ieb_pkg::ACT_READ: begin
        if (tx_pos < tx_count) begin
          pend_hit_next = 1'b1;
          tx_pos_next   = tx_pos + CW'(1);
        end else begin
          pend_byte_next = ieb_pkg::EMPTY_BYTE;
        end
      end
      ieb_pkg::ACT_WRITE: begin
        if (rx_count < FULL) begin
          wr_en         = 1'b1;
          rx_count_next = rx_count + CW'(1);
          pend_ack_next = (rx_count != LAST);
        end else begin
          pend_ack_next = 1'b0;
        end
      end
      ieb_pkg::ACT_STOP: begin
        rx_count_next = '0;
        tx_count_next = '0;
      end
      ieb_pkg::ACT_ERROR: pend_ack_next = 1'b0;
      default: pend_ack_next = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[rx_bank][rx_count[IW-1:0]] <= req.data.write_data;
    end
    if (accept) begin
      rd_data <= mem[!rx_bank][tx_pos[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= ieb_pkg::RESET_ADDRESS;
      rx_count    <= '0;
      tx_count    <= '0;
      tx_pos      <= '0;
      rx_bank     <= 1'b0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        own_address <= cfg_wdata;
      end
      if (accept) begin
        rx_count <= rx_count_next;
        tx_count <= tx_count_next;
        tx_pos   <= tx_pos_next;
        rx_bank  <= rx_bank_next;
        pend     <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_ack  <= pend_ack_next;
      pend_hit  <= pend_hit_next;
      pend_byte <= pend_byte_next;
    end
    if (move) begin
      out_data.ack        <= pend_ack;
      out_data.read_data  <= pend_hit ? rd_data : pend_byte;
      out_data.read_valid <= pend_hit;
    end
  end

endmodule
